FILE: hdl/eikonal_local_distance_update_core_assert.svh
// Assertion macros for the eikonal local distance update core.
// Depends on signals named clock and reset in the including module.
`ifndef EIKONAL_LOCAL_DISTANCE_UPDATE_CORE_ASSERT_SVH
`define EIKONAL_LOCAL_DISTANCE_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define ELDU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eldu assertion failed");
// Implication checked in the next cycle.
`define ELDU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eldu assertion failed");
`else
`define ELDU_ASSERT_NOW(label, ante, cons)
`define ELDU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/eldu_pkg.sv
// Shared constants, types and a helper function of the eikonal distance update.
// No dependencies.
package eldu_pkg;

   localparam int FRAC_BITS = 16;
   localparam logic [30:0] GRID_SPACING_RESET = 31'(1 << FRAC_BITS);
   localparam int ROOT_STEPS = 32;
   localparam logic [31:0] MAG_ABSENT = 32'hFFFF_FFFF;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FIXED = 2'd1;
   localparam logic [1:0] STATUS_MIXED    = 2'd2;

   // Values that ride along with a cell through the arithmetic.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [32:0] d1;
      logic [1:0]  n;
      logic        neg;
      logic [1:0]  status;
   } side_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] disc2;
      logic [63:0] disc3;
      side_type    side;
   } front_out_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] r2;
      logic [31:0] r3;
      side_type    side;
   } root_out_type;

   typedef struct packed {
      logic [3:0] q;
      logic [1:0] r;
   } div3_type;

   // One radix-16 digit of a division by three: remainder in, digit and remainder out.
   function automatic div3_type div3_step(input logic [1:0] rem, input logic [3:0] nib);
      logic [5:0]  cur;
      logic [11:0] prod;
      logic [5:0]  left;
      div3_type    res;
      cur   = {rem, nib};
      prod  = 12'(cur) * 12'd43;
      res.q = prod[10:7];
      left  = cur - ({2'b00, res.q} + {1'b0, res.q, 1'b0});
      res.r = left[1:0];
      return res;
   endfunction

endpackage

FILE: hdl/eldu_if.sv
// Handshake channel interfaces for the cell request and the distance response.
// No dependencies.
interface eldu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] phi_x_minus;
   logic signed [31:0] phi_x_plus;
   logic signed [31:0] phi_y_minus;
   logic signed [31:0] phi_y_plus;
   logic signed [31:0] phi_z_minus;
   logic signed [31:0] phi_z_plus;
   logic               fixed_x_minus;
   logic               fixed_x_plus;
   logic               fixed_y_minus;
   logic               fixed_y_plus;
   logic               fixed_z_minus;
   logic               fixed_z_plus;

   modport source(output valid, phi_x_minus, phi_x_plus, phi_y_minus, phi_y_plus,
                  phi_z_minus, phi_z_plus, fixed_x_minus, fixed_x_plus, fixed_y_minus,
                  fixed_y_plus, fixed_z_minus, fixed_z_plus, input ready);
   modport sink(input valid, phi_x_minus, phi_x_plus, phi_y_minus, phi_y_plus,
                phi_z_minus, phi_z_plus, fixed_x_minus, fixed_x_plus, fixed_y_minus,
                fixed_y_plus, fixed_z_minus, fixed_z_plus, output ready);
endinterface

interface eldu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_distance;
   logic [1:0]         status;

   modport source(output valid, new_distance, status, input ready);
   modport sink(input valid, new_distance, status, output ready);
endinterface

FILE: hdl/eikonal_local_distance_update_core.sv
// Eikonal local distance update core: one cell distance per accepted request word.
// Depends on eldu_pkg, eldu_if, eldu_front, eldu_root, eldu_back and the assert header.
//
// Usage:
//   req_chan carries the six axis neighbour values and their fixed flags; a word is
//   taken at a rising clock edge with valid and ready high. rsp_chan returns one word
//   per request, in order: the new signed distance (Q15.16, saturated) and a status
//   (ok, no fixed neighbour, mixed neighbour signs).
//   csr_write_enable with csr_write_data sets the grid spacing; write it only while
//   no request is in flight.
//   Between acceptance and rsp_chan.valid lie six front stages, one stage per
//   result bit in the two 32-step square roots, and three back stages.
//   Throughput is one word per cycle while the receiver does not stall, set by the fully pipelined square roots.
//   When the receiver holds ready low with a word waiting, the whole pipeline holds
//   its contents and req_chan.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and sets the grid spacing to one cell unit.
module eikonal_local_distance_update_core import eldu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   eldu_req_if.sink    req_chan,
   eldu_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [30:0] csr_write_data
);

`include "eikonal_local_distance_update_core_assert.svh"

   logic          advance;
   logic [30:0]   grid_spacing_ff;
   front_out_type front_out;
   root_out_type  root_out;

   // Grid spacing register.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_spacing_ff <= GRID_SPACING_RESET;
      end else if (csr_write_enable) begin
         grid_spacing_ff <= csr_write_data;
      end
   end

   eldu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_chan     (req_chan),
      .grid_spacing (grid_spacing_ff),
      .front_out    (front_out)
   );

   eldu_root u_root (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .front_out (front_out),
      .root_out  (root_out)
   );

   eldu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .root_out (root_out),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

   // Checks on the response and the stall path.
   `ELDU_ASSERT_NOW(a_status_code, rsp_chan.valid, (rsp_chan.status == STATUS_OK || rsp_chan.status == STATUS_NO_FIXED || rsp_chan.status == STATUS_MIXED))
   `ELDU_ASSERT_NOW(a_error_zero, (rsp_chan.valid && rsp_chan.status != STATUS_OK), (rsp_chan.new_distance == 32'sd0))
   `ELDU_ASSERT_NOW(a_stall_blocks, (rsp_chan.valid && !rsp_chan.ready), !req_chan.ready)
   `ELDU_ASSERT_NEXT(a_stall_holds_status, (rsp_chan.valid && !rsp_chan.ready), (rsp_chan.status == $past(rsp_chan.status)))

endmodule

FILE: hdl/eldu_front.sv
// Front pipeline: neighbour selection, sorting, squares and root arguments.
// Depends on eldu_pkg and eldu_req_if.
module eldu_front import eldu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   eldu_req_if.sink      req_chan,
   input  logic [30:0]   grid_spacing,
   output front_out_type front_out
);

   logic [2:0]         have;
   logic signed [31:0] pick [3];
   logic [31:0]        mag [3];
   logic               any_pos;
   logic               any_neg;

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   side_type s1_side_in, s1_side_ff;
   side_type s2_side_in, s2_side_ff;
   side_type s3_side_in, s3_side_ff;
   side_type s4_side_ff, s5_side_ff, s6_side_ff;
   logic [31:0] e1_in, e2_in, e3_in, e1_ff, e2_ff, e3_ff;
   logic [63:0] sq1_in, sq2_in, sq3_in, dx2_in, sq1_ff, sq2_ff, sq3_ff, dx2_ff;
   logic [63:0] s2sum_ff, s3sum_in, s3sum_ff, t2_in, t2_ff, t3_in, t3_ff;
   logic [63:0] disc2_in, disc3_in, disc2_ff, disc3_ff;
   logic [31:0] x0, x1, x2, tmp;

   assign req_chan.ready = advance;

   // Pick one neighbour per axis, check signs and take magnitudes.
   always_comb begin
      have[0] = req_chan.fixed_x_minus | req_chan.fixed_x_plus;
      have[1] = req_chan.fixed_y_minus | req_chan.fixed_y_plus;
      have[2] = req_chan.fixed_z_minus | req_chan.fixed_z_plus;
      pick[0] = req_chan.fixed_x_minus ? req_chan.phi_x_minus : req_chan.phi_x_plus;
      pick[1] = req_chan.fixed_y_minus ? req_chan.phi_y_minus : req_chan.phi_y_plus;
      pick[2] = req_chan.fixed_z_minus ? req_chan.phi_z_minus : req_chan.phi_z_plus;
      any_pos = 1'b0;
      any_neg = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (have[i] && (pick[i] > 32'sd0)) any_pos = 1'b1;
         if (have[i] && pick[i][31]) any_neg = 1'b1;
         if (!have[i]) mag[i] = MAG_ABSENT;
         else if (pick[i][31]) mag[i] = $unsigned(~pick[i]) + 32'd1;
         else mag[i] = $unsigned(pick[i]);
      end
      s1_side_in     = '0;
      s1_side_in.a   = mag[0];
      s1_side_in.b   = mag[1];
      s1_side_in.c   = mag[2];
      s1_side_in.n   = 2'(have[0]) + 2'(have[1]) + 2'(have[2]);
      s1_side_in.neg = any_neg;
      if (have == 3'b000) s1_side_in.status = STATUS_NO_FIXED;
      else if (any_pos && any_neg) s1_side_in.status = STATUS_MIXED;
      else s1_side_in.status = STATUS_OK;
   end

   // Sort the magnitudes with three compare-exchanges; absent axes sink to the top.
   always_comb begin
      x0  = s1_side_ff.a;
      x1  = s1_side_ff.b;
      x2  = s1_side_ff.c;
      tmp = x0;
      if (x1 < x0) begin tmp = x0; x0 = x1; x1 = tmp; end
      if (x2 < x1) begin tmp = x1; x1 = x2; x2 = tmp; end
      if (x1 < x0) begin tmp = x0; x0 = x1; x1 = tmp; end
      s2_side_in   = s1_side_ff;
      s2_side_in.a = x0;
      s2_side_in.b = x1;
      s2_side_in.c = x2;
   end

   // Differences and the one-neighbour estimate.
   always_comb begin
      e1_in         = s2_side_ff.b - s2_side_ff.a;
      e2_in         = s2_side_ff.c - s2_side_ff.b;
      e3_in         = s2_side_ff.c - s2_side_ff.a;
      s3_side_in    = s2_side_ff;
      s3_side_in.d1 = 33'(s2_side_ff.a) + 33'(grid_spacing);
   end

   // Squares of the differences and of the spacing.
   always_comb begin
      sq1_in = 64'(e1_ff) * 64'(e1_ff);
      sq2_in = 64'(e2_ff) * 64'(e2_ff);
      sq3_in = 64'(e3_ff) * 64'(e3_ff);
      dx2_in = 64'(grid_spacing) * 64'(grid_spacing);
   end

   // Sums of squares and scaled spacing terms.
   always_comb begin
      s3sum_in = sq1_ff + sq2_ff + sq3_ff;
      t2_in    = dx2_ff << 1;
      t3_in    = dx2_ff + (dx2_ff << 1);
   end

   // Root arguments, clamped at zero.
   always_comb begin
      disc2_in = (s2sum_ff >= t2_ff) ? 64'd0 : t2_ff - s2sum_ff;
      disc3_in = (s3sum_ff >= t3_ff) ? 64'd0 : t3_ff - s3sum_ff;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s2_side_in;
         s3_side_ff <= s3_side_in;
         e1_ff      <= e1_in;
         e2_ff      <= e2_in;
         e3_ff      <= e3_in;
         s4_side_ff <= s3_side_ff;
         sq1_ff     <= sq1_in;
         sq2_ff     <= sq2_in;
         sq3_ff     <= sq3_in;
         dx2_ff     <= dx2_in;
         s5_side_ff <= s4_side_ff;
         s2sum_ff   <= sq1_ff;
         s3sum_ff   <= s3sum_in;
         t2_ff      <= t2_in;
         t3_ff      <= t3_in;
         s6_side_ff <= s5_side_ff;
         disc2_ff   <= disc2_in;
         disc3_ff   <= disc3_in;
      end
   end

   assign front_out.valid = s6_valid_ff;
   assign front_out.disc2 = disc2_ff;
   assign front_out.disc3 = disc3_ff;
   assign front_out.side  = s6_side_ff;

endmodule

FILE: hdl/eldu_root.sv
// Two pipelined bit-per-stage integer square roots with the cell's sideband.
// Depends on eldu_pkg.
module eldu_root import eldu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  front_out_type front_out,
   output root_out_type  root_out
);

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } root_state_type;

   // One restoring step: subtract when the trial value fits.
   function automatic root_state_type root_step(input root_state_type st,
                                                input logic [63:0] bitval);
      logic [63:0]    trial;
      root_state_type res;
      trial = st.r + bitval;
      if (st.v >= trial) begin
         res.v = st.v - trial;
         res.r = (st.r >> 1) + bitval;
      end else begin
         res.v = st.v;
         res.r = st.r >> 1;
      end
      return res;
   endfunction

   root_state_type state_in [2][ROOT_STEPS];
   root_state_type state_ff [2][ROOT_STEPS];
   side_type       side_ff [ROOT_STEPS];
   logic           valid_ff [ROOT_STEPS];

   // One step per stage for each of the two roots.
   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
      localparam logic [63:0] BITVAL = 64'(1) << (62 - 2 * g);
      if (g == 0) begin : g_first
         always_comb begin
            state_in[0][g] = root_step('{v: front_out.disc2, r: 64'd0}, BITVAL);
            state_in[1][g] = root_step('{v: front_out.disc3, r: 64'd0}, BITVAL);
         end
      end else begin : g_rest
         always_comb begin
            state_in[0][g] = root_step(state_ff[0][g-1], BITVAL);
            state_in[1][g] = root_step(state_ff[1][g-1], BITVAL);
         end
      end
   end

   // Valid bits travel with the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= front_out.valid;
         for (int i = 1; i < ROOT_STEPS; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // Root state and sideband per stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= front_out.side;
         for (int i = 1; i < ROOT_STEPS; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < ROOT_STEPS; i++) begin
            state_ff[0][i] <= state_in[0][i];
            state_ff[1][i] <= state_in[1][i];
         end
      end
   end

   assign root_out.valid = valid_ff[ROOT_STEPS-1];
   assign root_out.r2    = state_ff[0][ROOT_STEPS-1].r[31:0];
   assign root_out.r3    = state_ff[1][ROOT_STEPS-1].r[31:0];
   assign root_out.side  = side_ff[ROOT_STEPS-1];

endmodule

FILE: hdl/eldu_back.sv
// Back pipeline: candidate distances, division by three, sign and saturation.
// Depends on eldu_pkg and eldu_rsp_if.
module eldu_back import eldu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  root_out_type root_out,
   output logic         advance,
   eldu_rsp_if.source   rsp_chan
);

   logic        b1_valid_ff, b2_valid_ff, out_valid_ff;
   logic [33:0] x2, x3_in, x3_ff;
   logic [32:0] dsel_in, dsel_ff, dsel2_ff;
   logic [31:0] c_ff;
   logic [1:0]  n_ff, status_ff, status2_ff, out_status_ff, out_status_in;
   logic        neg_ff, neg2_ff, use3_in, use3_ff;
   logic [35:0] xpad;
   logic [19:0] qhi_in, qhi_ff;
   logic [1:0]  rem_in, rem_ff;
   logic [15:0] xlo_ff;
   logic [15:0] qlo;
   logic [35:0] d3;
   logic [33:0] dfin;
   logic [31:0] mag;
   logic [31:0] dist_in, dist_ff;
   div3_type    st_hi, st_lo;
   logic [1:0]  rem_hi, rem_lo;

   assign advance = !out_valid_ff || rsp_chan.ready;

   // Two-neighbour candidate and its choice against the one-neighbour estimate.
   always_comb begin
      x2    = 34'(root_out.side.a) + 34'(root_out.side.b) + 34'(root_out.r2);
      x3_in = 34'(root_out.side.a) + 34'(root_out.side.b) + 34'(root_out.side.c)
              + 34'(root_out.r3);
      if ((root_out.side.n >= 2'd2) && (root_out.side.d1 > 33'(root_out.side.b)))
         dsel_in = x2[33:1];
      else
         dsel_in = root_out.side.d1;
   end

   // Upper digits of the three-neighbour sum divided by three.
   always_comb begin
      xpad    = {2'b00, x3_ff};
      rem_hi  = 2'd0;
      qhi_in  = '0;
      for (int k = 4; k >= 0; k--) begin
         st_hi = div3_step(rem_hi, xpad[4 * (k + 4) +: 4]);
         qhi_in[4 * k +: 4] = st_hi.q;
         rem_hi = st_hi.r;
      end
      rem_in  = rem_hi;
      use3_in = (n_ff == 2'd3) && (dsel_ff > 33'(c_ff));
   end

   // Lower digits, final choice, sign and saturation.
   always_comb begin
      rem_lo = rem_ff;
      qlo    = '0;
      for (int k = 3; k >= 0; k--) begin
         st_lo = div3_step(rem_lo, xlo_ff[4 * k +: 4]);
         qlo[4 * k +: 4] = st_lo.q;
         rem_lo = st_lo.r;
      end
      d3   = {qhi_ff, qlo};
      dfin = use3_ff ? d3[33:0] : {1'b0, dsel2_ff};
      if (neg2_ff) begin
         mag     = (dfin > 34'h0_8000_0000) ? 32'h8000_0000 : dfin[31:0];
         dist_in = ~mag + 32'd1;
      end else begin
         mag     = (dfin > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : dfin[31:0];
         dist_in = mag;
      end
      out_status_in = status2_ff;
      if (status2_ff != STATUS_OK) dist_in = 32'd0;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= root_out.valid;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         x3_ff         <= x3_in;
         dsel_ff       <= dsel_in;
         c_ff          <= root_out.side.c;
         n_ff          <= root_out.side.n;
         neg_ff        <= root_out.side.neg;
         status_ff     <= root_out.side.status;
         qhi_ff        <= qhi_in;
         rem_ff        <= rem_in;
         xlo_ff        <= x3_ff[15:0];
         use3_ff       <= use3_in;
         dsel2_ff      <= dsel_ff;
         neg2_ff       <= neg_ff;
         status2_ff    <= status_ff;
         dist_ff       <= dist_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.new_distance = $signed(dist_ff);
   assign rsp_chan.status       = out_status_ff;

endmodule

FILE: sim/eikonal_local_distance_update_core_test.sv
// Testbench for the eikonal local distance update core: directed and random cells,
// checked word by word against an in-bench distance predictor.
// Depends on eldu_pkg, eldu_if and the core RTL.
module eikonal_local_distance_update_core_test;
   import eldu_pkg::*;

   typedef struct {
      logic signed [31:0] phi[6];
      logic               fix[6];
   } cell_type;

   typedef struct {
      logic [31:0] distance_val;
      logic [1:0]  status;
   } distance_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [30:0] csr_write_data;

   eldu_req_if req_chan();
   eldu_rsp_if rsp_chan();

   eikonal_local_distance_update_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   distance_type pending_distances[$];
   logic [30:0]  spacing;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           error_count;
   int           cell_count;
   int           result_count;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #40000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Predicts the distance word for one cell under the current spacing.
   function automatic distance_type predict_distance(input cell_type c);
      distance_type res;
      logic [63:0]  m[3];
      logic [63:0]  t, s, disc, d, dx, dx2, e1, e2, e3, tmp;
      logic signed [63:0] v;
      int n;
      bit pos, neg;
      n = 0;
      pos = 0;
      neg = 0;
      for (int ax = 0; ax < 3; ax++) begin
         if (c.fix[2*ax]) v = c.phi[2*ax];
         else if (c.fix[2*ax+1]) v = c.phi[2*ax+1];
         else continue;
         if (v > 0) pos = 1;
         if (v < 0) neg = 1;
         m[n] = (v < 0) ? 64'(-v) : 64'(v);
         n++;
      end
      if (n == 0) begin
         res.distance_val = 0;
         res.status = STATUS_NO_FIXED;
         return res;
      end
      if (pos && neg) begin
         res.distance_val = 0;
         res.status = STATUS_MIXED;
         return res;
      end
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (m[j] < m[i]) begin
               tmp = m[i];
               m[i] = m[j];
               m[j] = tmp;
            end
      dx = 64'(spacing);
      dx2 = dx * dx;
      d = m[0] + dx;
      if (n >= 2 && d > m[1]) begin
         e1 = m[1] - m[0];
         t = 2 * dx2;
         s = e1 * e1;
         disc = (s >= t) ? 0 : t - s;
         d = (m[0] + m[1] + int_sqrt(disc)) >> 1;
      end
      if (n == 3 && d > m[2]) begin
         e1 = m[1] - m[0];
         e2 = m[2] - m[1];
         e3 = m[2] - m[0];
         t = 3 * dx2;
         s = e1 * e1 + e2 * e2 + e3 * e3;
         disc = (s >= t) ? 0 : t - s;
         d = (m[0] + m[1] + m[2] + int_sqrt(disc)) / 3;
      end
      if (neg) begin
         if (d > 64'h8000_0000) d = 64'h8000_0000;
         res.distance_val = 32'(-d);
      end else begin
         if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
         res.distance_val = 32'(d);
      end
      res.status = STATUS_OK;
      return res;
   endfunction

   // Sends one cell word, idling first at random; valid stays high between
   // back-to-back words and is dropped only while idling or draining.
   task automatic send_cell(input cell_type c);
      distance_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.phi_x_minus <= c.phi[0];
      req_chan.phi_x_plus <= c.phi[1];
      req_chan.phi_y_minus <= c.phi[2];
      req_chan.phi_y_plus <= c.phi[3];
      req_chan.phi_z_minus <= c.phi[4];
      req_chan.phi_z_plus <= c.phi[5];
      req_chan.fixed_x_minus <= c.fix[0];
      req_chan.fixed_x_plus <= c.fix[1];
      req_chan.fixed_y_minus <= c.fix[2];
      req_chan.fixed_y_plus <= c.fix[3];
      req_chan.fixed_z_minus <= c.fix[4];
      req_chan.fixed_z_plus <= c.fix[5];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want = predict_distance(c);
      pending_distances = {pending_distances, want};
      cell_count++;
   endtask

   // Receiver ready pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compares each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      distance_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected word distance=%h status=%0d", $time,
                     rsp_chan.new_distance, rsp_chan.status);
            error_count++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_chan.new_distance !== want.distance_val) begin
               $display("%0t: new_distance expected %h actual %h", $time,
                        want.distance_val, rsp_chan.new_distance);
               error_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_chan.status);
               error_count++;
            end
         end
      end
   end

   // Stops sending, waits for all predictions to drain, then lets the pipeline settle.
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_spacing(input logic [30:0] value);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      spacing = value;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_phi(input int sign_mode);
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = $urandom;
         1: v = $urandom_range(32'h0004_0000);
         2: v = $urandom_range(32'h0000_1000);
         3: v = 0;
         4: v = 32'h7FFF_FFFF - $urandom_range(3);
         default: v = $urandom_range(32'h0100_0000);
      endcase
      if (sign_mode == 1) v = {1'b0, v[30:0]};
      if (sign_mode == 2) v = (v == 0) ? 32'h8000_0000 : -{1'b0, v[30:0]};
      return v;
   endfunction

   function automatic cell_type rand_cell();
      cell_type c;
      int mode;
      mode = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < 6; i++) begin
         c.phi[i] = rand_phi(mode);
         c.fix[i] = ($urandom_range(3) != 0);
      end
      if ($urandom_range(7) == 0)
         for (int i = 0; i < 6; i++) c.fix[i] = $urandom_range(1);
      return c;
   endfunction

   function automatic cell_type make_cell(input logic signed [31:0] x, y, z,
                                          input logic [5:0] fix);
      cell_type c;
      for (int i = 0; i < 6; i++) c.fix[i] = fix[i];
      c.phi[0] = x; c.phi[1] = -x;
      c.phi[2] = y; c.phi[3] = -y;
      c.phi[4] = z; c.phi[5] = -z;
      return c;
   endfunction

   // Directed cells: no fixed neighbour, mixed signs, zeros, both sides fixed, extremes.
   task automatic test_directed();
      send_cell(make_cell(32'h10000, 32'h20000, 32'h30000, 6'b000000));
      send_cell(make_cell(32'h10000, -32'sh20000, 32'h30000, 6'b010101));
      send_cell(make_cell(0, 0, 0, 6'b010101));
      send_cell(make_cell(0, -32'sh8000, 0, 6'b010101));
      send_cell(make_cell(32'h10000, 32'h18000, 32'h20000, 6'b111111));
      send_cell(make_cell(32'h10000, 32'h18000, 32'h20000, 6'b101010));
      send_cell(make_cell(32'h10000, 0, 0, 6'b000001));
      send_cell(make_cell(32'h10000, 32'h10000, 0, 6'b000101));
      send_cell(make_cell(32'h10000, 32'h10000, 32'h10000, 6'b010101));
      send_cell(make_cell(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 6'b010101));
      send_cell(make_cell(32'h80000000, 32'h80000000, 32'h80000000, 6'b010101));
      send_cell(make_cell(32'h80000000, 0, 0, 6'b000001));
      send_cell(make_cell(-32'sh10000, -32'sh50000, -32'sh10000, 6'b101010));
      send_cell(make_cell(32'h7FFFFFFF, 32'h0, 32'h0, 6'b000010));
   endtask

   task automatic test_random(input int count);
      repeat (count) send_cell(rand_cell());
   endtask

   task automatic test_spacing_extremes();
      write_spacing(31'd1);
      test_directed();
      test_random(60);
      write_spacing(31'h7FFF_FFFF);
      test_directed();
      test_random(60);
      write_spacing(31'd0);
      test_random(20);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.phi_x_minus = '0;
      req_chan.phi_x_plus = '0;
      req_chan.phi_y_minus = '0;
      req_chan.phi_y_plus = '0;
      req_chan.phi_z_minus = '0;
      req_chan.phi_z_plus = '0;
      req_chan.fixed_x_minus = 1'b0;
      req_chan.fixed_x_plus = 1'b0;
      req_chan.fixed_y_minus = 1'b0;
      req_chan.fixed_y_plus = 1'b0;
      req_chan.fixed_z_minus = 1'b0;
      req_chan.fixed_z_plus = 1'b0;
      spacing = GRID_SPACING_RESET;
      error_count = 0;
      cell_count = 0;
      result_count = 0;
      send_idle_pct = 13;
      recv_idle_pct = 56;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(500);
      send_idle_pct = 56;
      recv_idle_pct = 13;
      write_spacing(31'h0000_8000);
      test_random(400);
      test_spacing_extremes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_spacing(31'h0003_0000);
      test_random(570);

      drain_pipeline();
      $display("Checked %0d cells and %0d result words over several grid spacings,",
               cell_count, result_count);
      $display("including no-fixed, mixed-sign, zero and saturation cases.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/eldu_pkg.sv
hdl/eldu_if.sv
hdl/eldu_front.sv
hdl/eldu_root.sv
hdl/eldu_back.sv
hdl/eikonal_local_distance_update_core.sv
sim/eikonal_local_distance_update_core_test.sv
